// ----- design/ftfc_pkg.sv -----
// Shared types, command and status codes for the fixed-timestep frame clock.
package ftfc_pkg;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_CONSUME = 2'd2;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_NOT_INIT = 3'd1;
    localparam logic [2:0] ST_BAD_CFG  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_NO_STEP  = 3'd5;

    localparam logic [2:0] REG_STEP   = 3'd0;
    localparam logic [2:0] REG_CLAMP  = 3'd1;
    localparam logic [2:0] REG_LIMIT  = 3'd2;
    localparam logic [2:0] REG_SCALE  = 3'd3;
    localparam logic [2:0] REG_PAUSED = 3'd4;

    localparam int DIV_BITS = 49;
    localparam logic [10:0] SCALE_MAX = 11'd1024;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;      // capture the accepted transfer
        logic do_init;      // check and latch config
        logic do_prep;      // clamp, scale, overflow checks
        logic div_start;    // load divider
        logic div_step;     // one restoring-divide step
        logic do_commit;    // finish advance
        logic do_consume;   // consume one step
        logic out_load;     // capture result
    } ftfc_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic       div_done;
        logic [1:0] cur_cmd;    // command of the item in progress
    } ftfc_sts_t;

endpackage

// ----- design/ftfc_datapath.sv -----
// Datapath: state registers, advance arithmetic, serial divider, result register.
module ftfc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ftfc_pkg::ftfc_cmd_t  cmd_i,
    output ftfc_pkg::ftfc_sts_t  sts_o,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           s_cmd,
    input  logic [31:0]          s_frame_delta,
    output logic [2:0]           m_status,
    output logic                 m_accepted,
    output logic [7:0]           m_pending_steps,
    output logic [63:0]          m_frame_count,
    output logic [63:0]          m_fixed_step_count,
    output logic [47:0]          m_unscaled_time,
    output logic [47:0]          m_scaled_time,
    output logic [31:0]          m_unscaled_delta,
    output logic [33:0]          m_scaled_delta,
    output logic [63:0]          m_dropped_step_count,
    output logic [47:0]          m_dropped_time,
    output logic [47:0]          m_leftover_time
);
    import ftfc_pkg::*;

    // configuration registers
    logic [31:0] step_cfg_reg, clamp_cfg_reg;
    logic [7:0]  limit_cfg_reg;
    logic [10:0] scale_cfg_reg;
    logic        paused_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cfg_reg  <= 32'd1092;
            clamp_cfg_reg <= 32'd16384;
            limit_cfg_reg <= 8'd5;
            scale_cfg_reg <= 11'd256;
            paused_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEP:   step_cfg_reg  <= cfg_data;
                REG_CLAMP:  clamp_cfg_reg <= cfg_data;
                REG_LIMIT:  limit_cfg_reg <= cfg_data[7:0];
                REG_SCALE:  scale_cfg_reg <= cfg_data[10:0];
                REG_PAUSED: paused_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // accepted input transfer, held for the whole command
    logic [1:0]  cmd_in_reg;
    logic [31:0] delta_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_in_reg   <= CMD_INIT;
            delta_in_reg <= '0;
        end else if (cmd_i.load_in) begin
            cmd_in_reg   <= s_cmd;
            delta_in_reg <= s_frame_delta;
        end
    end

    assign sts_o.cur_cmd = cmd_in_reg;

    // clock state
    logic        ready_reg;
    logic [31:0] lstep_reg, lclamp_reg;
    logic [7:0]  llimit_reg, pend_reg;
    logic [47:0] acc_reg, ptime_reg, stime_reg, dtime_reg;
    logic [63:0] frames_reg, steps_reg, dsteps_reg;
    logic [31:0] ldelta_reg;
    logic [33:0] sdelta_reg;
    logic [2:0]  status_reg;

    // advance working registers
    logic [31:0] d_reg;
    logic [33:0] sd_reg;
    logic [48:0] accsum_reg;
    logic [48:0] rem_reg;
    logic [48:0] quo_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] d_c;
    logic [10:0] sc_c;
    logic [42:0] prod_c;
    logic [33:0] sd_c;
    logic        ovf_c;

    // clamp, scale and overflow checks
    always_comb begin
        d_c    = (delta_in_reg > lclamp_reg) ? lclamp_reg : delta_in_reg;
        sc_c   = (scale_cfg_reg > SCALE_MAX) ? SCALE_MAX : scale_cfg_reg;
        prod_c = {11'd0, d_c} * {32'd0, sc_c};
        sd_c   = paused_reg ? 34'd0 : prod_c[41:8];
        ovf_c  = ({1'b0, ptime_reg} + {17'd0, d_c} > 49'h0_FFFF_FFFF_FFFF)
              || ({1'b0, stime_reg} + {15'd0, sd_c} > 49'h0_FFFF_FFFF_FFFF)
              || (&frames_reg)
              || ({1'b0, acc_reg} + {15'd0, sd_c} > 49'h0_FFFF_FFFF_FFFF);
    end

    // restoring divider step
    logic [49:0] trial_c;
    always_comb begin
        trial_c = {rem_reg, quo_reg[48]} - {18'd0, lstep_reg};
    end

    // commit values; dropped time is quotient*step minus limit*step
    logic [48:0] rem_fin_c;
    logic        over_c;
    logic [63:0] dropn_c;
    logic [39:0] limprod_c;
    logic [48:0] dropt_c;
    logic        dovf_c;
    always_comb begin
        rem_fin_c = rem_reg;
        over_c    = quo_reg > {41'd0, llimit_reg};
        dropn_c   = {15'd0, quo_reg} - {56'd0, llimit_reg};
        limprod_c = {32'd0, llimit_reg} * {8'd0, lstep_reg};
        dropt_c   = accsum_reg - rem_reg - {9'd0, limprod_c};
        dovf_c = ({2'd0, dtime_reg} + {1'b0, dropt_c} > 50'h0_FFFF_FFFF_FFFF)
              || (dsteps_reg > ~dropn_c);
    end

    assign sts_o.div_done = (cnt_reg == 6'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg  <= 1'b0;
            lstep_reg  <= '0; lclamp_reg <= '0; llimit_reg <= '0;
            pend_reg   <= '0; acc_reg <= '0; ptime_reg <= '0; stime_reg <= '0;
            dtime_reg  <= '0; frames_reg <= '0; steps_reg <= '0;
            dsteps_reg <= '0; ldelta_reg <= '0; sdelta_reg <= '0;
            status_reg <= ST_NONE;
            cnt_reg    <= '0;
        end else begin
            if (cmd_i.do_init) begin
                if (step_cfg_reg == 32'd0 || clamp_cfg_reg < step_cfg_reg
                    || limit_cfg_reg == 8'd0) begin
                    status_reg <= ST_BAD_CFG;
                end else begin
                    status_reg <= ST_NONE;
                    ready_reg  <= 1'b1;
                    lstep_reg  <= step_cfg_reg; lclamp_reg <= clamp_cfg_reg;
                    llimit_reg <= limit_cfg_reg;
                    pend_reg   <= '0; acc_reg <= '0; ptime_reg <= '0;
                    stime_reg  <= '0; dtime_reg <= '0; frames_reg <= '0;
                    steps_reg  <= '0; dsteps_reg <= '0; ldelta_reg <= '0;
                    sdelta_reg <= '0;
                end
            end
            if (cmd_i.do_prep) begin
                d_reg      <= d_c;
                sd_reg     <= sd_c;
                accsum_reg <= {1'b0, acc_reg} + {15'd0, sd_c};
                if (!ready_reg || lstep_reg == 32'd0) status_reg <= ST_NOT_INIT;
                else if (ovf_c)                       status_reg <= ST_OVERFLOW;
                else                                  status_reg <= ST_NONE;
            end
            if (cmd_i.div_start) begin
                rem_reg <= '0;
                quo_reg <= accsum_reg;
                cnt_reg <= 6'(DIV_BITS);
            end
            if (cmd_i.div_step) begin
                if (!trial_c[49]) rem_reg <= trial_c[48:0];
                else              rem_reg <= {rem_reg[47:0], quo_reg[48]};
                quo_reg <= {quo_reg[47:0], ~trial_c[49]};
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (cmd_i.do_commit && status_reg == ST_NONE) begin
                if (over_c && dovf_c) begin
                    status_reg <= ST_OVERFLOW;
                end else begin
                    ptime_reg  <= ptime_reg + {16'd0, d_reg};
                    stime_reg  <= stime_reg + {14'd0, sd_reg};
                    frames_reg <= frames_reg + 64'd1;
                    ldelta_reg <= d_reg;
                    sdelta_reg <= sd_reg;
                    acc_reg    <= rem_fin_c[47:0];
                    if (over_c) begin
                        status_reg <= ST_OVERRUN;
                        pend_reg   <= llimit_reg;
                        dsteps_reg <= dsteps_reg + dropn_c;
                        dtime_reg  <= dtime_reg + dropt_c[47:0];
                    end else begin
                        pend_reg <= quo_reg[7:0];
                    end
                end
            end
            if (cmd_i.do_consume) begin
                if (!ready_reg)           status_reg <= ST_NOT_INIT;
                else if (pend_reg == 8'd0) status_reg <= ST_NO_STEP;
                else if (&steps_reg)      status_reg <= ST_OVERFLOW;
                else begin
                    status_reg <= ST_NONE;
                    pend_reg   <= pend_reg - 8'd1;
                    steps_reg  <= steps_reg + 64'd1;
                end
            end
        end
    end

    // result register; the unused command reports no status
    logic       accepted_c;
    logic [2:0] status_out_c;
    always_comb begin
        unique case (cmd_in_reg)
            CMD_INIT, CMD_CONSUME: begin
                accepted_c   = (status_reg == ST_NONE);
                status_out_c = status_reg;
            end
            CMD_ADVANCE: begin
                accepted_c   = (status_reg == ST_NONE) || (status_reg == ST_OVERRUN);
                status_out_c = status_reg;
            end
            default: begin
                accepted_c   = 1'b0;
                status_out_c = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_status             <= status_out_c;
            m_accepted           <= accepted_c;
            m_pending_steps      <= pend_reg;
            m_frame_count        <= frames_reg;
            m_fixed_step_count   <= steps_reg;
            m_unscaled_time      <= ptime_reg;
            m_scaled_time        <= stime_reg;
            m_unscaled_delta     <= ldelta_reg;
            m_scaled_delta       <= sdelta_reg;
            m_dropped_step_count <= dsteps_reg;
            m_dropped_time       <= dtime_reg;
            m_leftover_time      <= acc_reg;
        end
    end

endmodule

// ----- design/ftfc_ctrl.sv -----
// Controller: sequences init, advance (with serial divide) and consume.
module ftfc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ftfc_pkg::ftfc_cmd_t  cmd_o,
    input  ftfc_pkg::ftfc_sts_t  sts_i
);
    import ftfc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_PREP = 3'd2,
                           S_DIVL = 3'd3, S_DIV = 3'd4, S_COMMIT = 3'd5,
                           S_OUT = 3'd6, S_HOLD = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg;

    assign m_valid = mvalid_reg;
    // take a new item when idle and the result register is free
    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                cmd_o.load_in = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                unique case (sts_i.cur_cmd)
                    CMD_INIT:    begin cmd_o.do_init = 1'b1;    state_next = S_OUT; end
                    CMD_ADVANCE: begin cmd_o.do_prep = 1'b1;    state_next = S_PREP; end
                    CMD_CONSUME: begin cmd_o.do_consume = 1'b1; state_next = S_OUT; end
                    default:     state_next = S_OUT;
                endcase
            end
            S_PREP:   begin cmd_o.div_start = 1'b1; state_next = S_DIVL; end
            S_DIVL:   state_next = S_DIV;
            S_DIV: begin
                if (sts_i.div_done) state_next = S_COMMIT;
                else                cmd_o.div_step = 1'b1;
            end
            S_COMMIT: begin cmd_o.do_commit = 1'b1; state_next = S_OUT; end
            S_OUT:    begin cmd_o.out_load = 1'b1; state_next = S_HOLD; end
            S_HOLD:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd_o.out_load)           mvalid_reg <= 1'b1;
            else if (m_ready)             mvalid_reg <= 1'b0;
        end
    end

endmodule

// ----- design/fixed_timestep_frame_clock.sv -----
// Top level of the fixed-timestep frame clock.
// Sequence: init, consume and unused commands pass through S_EXEC and S_OUT; advance
// runs S_EXEC, S_PREP, S_DIVL, S_DIV (serial divide of accumulator plus scaled delta by
// the step), S_COMMIT and S_OUT; every command then passes S_HOLD. One command at a time:
// a new command is accepted only after the result transfer of the last one.
// Reset (aresetn, synchronous, active low) clears clock state, config to defaults.
module fixed_timestep_frame_clock (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_frame_delta,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_accepted,
    output logic [7:0]  m_pending_steps,
    output logic [63:0] m_frame_count,
    output logic [63:0] m_fixed_step_count,
    output logic [47:0] m_unscaled_time,
    output logic [47:0] m_scaled_time,
    output logic [31:0] m_unscaled_delta,
    output logic [33:0] m_scaled_delta,
    output logic [63:0] m_dropped_step_count,
    output logic [47:0] m_dropped_time,
    output logic [47:0] m_leftover_time
);
    import ftfc_pkg::*;

    ftfc_cmd_t cmd;
    ftfc_sts_t sts;

    ftfc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd_o(cmd), .sts_i(sts)
    );

    ftfc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd_i(cmd), .sts_o(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_cmd(s_cmd), .s_frame_delta(s_frame_delta),
        .m_status(m_status), .m_accepted(m_accepted),
        .m_pending_steps(m_pending_steps), .m_frame_count(m_frame_count),
        .m_fixed_step_count(m_fixed_step_count),
        .m_unscaled_time(m_unscaled_time), .m_scaled_time(m_scaled_time),
        .m_unscaled_delta(m_unscaled_delta), .m_scaled_delta(m_scaled_delta),
        .m_dropped_step_count(m_dropped_step_count),
        .m_dropped_time(m_dropped_time), .m_leftover_time(m_leftover_time)
    );

endmodule
